FILE: rtl/rpc_record_deframer_defines.svh
// assertion macros shared by the rpc record deframer rtl
`ifndef RPC_RECORD_DEFRAMER_DEFINES_SVH
`define RPC_RECORD_DEFRAMER_DEFINES_SVH

// condition holds at every clock edge outside reset
`define RRD_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define RRD_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: rtl/rrd_pkg.sv
// package with result codes and constants of the rpc record deframer
package rrd_pkg;

   // result kinds
   typedef enum logic [2:0] {
      KIND_HEADER    = 3'd0,
      KIND_ARG_BYTE  = 3'd1,
      KIND_ARG_EMPTY = 3'd2,
      KIND_MSG_END   = 3'd3,
      KIND_LEN_ERROR = 3'd4,
      KIND_OVERRUN   = 3'd5
   } kind_type;

   // register indexes
   localparam logic [1:0] CSR_VERSION_FIRST  = 2'd0;
   localparam logic [1:0] CSR_VERSION_SECOND = 2'd1;
   localparam logic [1:0] CSR_MAX_SIZE       = 2'd2;

   localparam int          RRD_INDEX_BITS      = 14;
   localparam logic [31:0] HARD_SIZE_LIMIT     = 32'd65536;
   localparam logic [31:0] HEADER_BYTES        = 32'd16;
   localparam logic [31:0] VERSION_FIRST_RESET = 32'd1;
   localparam logic [31:0] VERSION_SECOND_RESET = 32'd2;
   localparam logic [16:0] MAX_SIZE_RESET      = 17'd65536;

endpackage

FILE: rtl/rpc_record_deframer.sv
// top level of the rpc record deframer: byte parser and result queue
//
// channel   direction  handshake             payload
// req_      in         req_valid/req_stall   req_data_byte
// rsp_      out        rsp_valid/rsp_stall   kind, version_ok, status_word, arg_count,
//                                            arg_index, arg_byte, arg_last, last
// csr_      in         csr_write             csr_index, csr_data
//
// one byte is parsed per cycle while req_stall is low, by counters and compares ahead of a four entry result queue.
// a byte yields zero, one or two results; a result is registered into the queue and offered once it reaches the head.
// req_stall rises while fewer than two queue entries are free.
// reset is synchronous and active high; no clearing pass is needed.
// a stalled result holds at the queue head until taken.
`include "rpc_record_deframer_defines.svh"

module rpc_record_deframer #(
   parameter int INDEX_BITS = rrd_pkg::RRD_INDEX_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // byte input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   // results
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_kind,
   output logic                  rsp_version_ok,
   output logic [31:0]           rsp_status_word,
   output logic [31:0]           rsp_arg_count,
   output logic [INDEX_BITS-1:0] rsp_arg_index,
   output logic [7:0]            rsp_arg_byte,
   output logic                  rsp_arg_last,
   output logic                  rsp_last,
   // configuration
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_data
);
   import rrd_pkg::*;

   localparam int DEPTH    = 4;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      PH_SIZE, PH_VERSION, PH_STATUS, PH_COUNT, PH_ARGLEN, PH_DATA, PH_PAD, PH_DRAIN
   } phase_type;

   typedef struct packed {
      kind_type              kind;
      logic                  version_ok;
      logic [31:0]           status_word;
      logic [31:0]           arg_count;
      logic [INDEX_BITS-1:0] arg_index;
      logic [7:0]            arg_byte;
      logic                  arg_last;
      logic                  last;
   } result_type;

   // configuration registers
   logic [31:0] version_first_ff, version_second_ff;
   logic [16:0] max_size_ff;

   // parser state
   phase_type             phase_ff, phase_in;
   logic [16:0]           byte_count_ff, byte_count_in;
   logic [16:0]           record_size_ff, record_size_in;
   logic [31:0]           word_ff, word_in;
   logic                  held_vok_ff, held_vok_in;
   logic [31:0]           held_status_ff, held_status_in;
   logic [31:0]           args_left_ff, args_left_in;
   logic [INDEX_BITS-1:0] cur_index_ff, cur_index_in;
   logic [15:0]           bytes_left_ff, bytes_left_in;
   logic [1:0]            pad_left_ff, pad_left_in;

   // result queue
   result_type            fifo_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0]   cnt_ff;

   logic       req_take, rsp_take;
   logic       emit_a, emit_b;
   result_type res_a, res_b, push0, push1;
   logic [1:0] push_cnt;
   logic [2:0] size_cnt;
   logic       word_done;
   logic [15:0] arg_len;

   assign req_stall = cnt_ff > CNT_BITS'(DEPTH - 2);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = cnt_ff != '0;
   assign rsp_take  = rsp_valid && !rsp_stall;

   // parse one byte
   always_comb begin
      phase_in       = phase_ff;
      byte_count_in  = byte_count_ff;
      record_size_in = record_size_ff;
      word_in        = word_ff;
      held_vok_in    = held_vok_ff;
      held_status_in = held_status_ff;
      args_left_in   = args_left_ff;
      cur_index_in   = cur_index_ff;
      bytes_left_in  = bytes_left_ff;
      pad_left_in    = pad_left_ff;
      emit_a         = 1'b0;
      emit_b         = 1'b0;
      res_a          = '0;
      res_b          = '0;
      size_cnt       = byte_count_ff[2:0] + 3'd1;
      word_done      = 1'b0;
      arg_len        = '0;
      if (req_take) begin
         word_in = {word_ff[23:0], req_data_byte};
         if (phase_ff == PH_SIZE) begin
            byte_count_in = {14'd0, size_cnt};
            if (size_cnt[2]) begin
               byte_count_in = '0;
               if (word_in > {15'd0, max_size_ff} || word_in > HARD_SIZE_LIMIT ||
                   word_in < HEADER_BYTES) begin
                  emit_a     = 1'b1;
                  res_a.kind = KIND_LEN_ERROR;
               end else begin
                  record_size_in = word_in[16:0];
                  byte_count_in  = 17'd4;
                  phase_in       = PH_VERSION;
               end
            end
         end else begin
            byte_count_in = byte_count_ff + 17'd1;
            word_done     = byte_count_in[1:0] == 2'd0;
            arg_len       = word_in[15:0];
            unique case (phase_ff)
               PH_VERSION: begin
                  if (word_done) begin
                     held_vok_in = (word_in == version_first_ff) ||
                                   (word_in == version_second_ff);
                     phase_in    = PH_STATUS;
                  end
               end
               PH_STATUS: begin
                  if (word_done) begin
                     held_status_in = word_in;
                     phase_in       = PH_COUNT;
                  end
               end
               PH_COUNT: begin
                  if (word_done) begin
                     args_left_in      = word_in;
                     cur_index_in      = '0;
                     emit_a            = 1'b1;
                     res_a.kind        = KIND_HEADER;
                     res_a.version_ok  = held_vok_ff;
                     res_a.status_word = held_status_ff;
                     res_a.arg_count   = word_in;
                     phase_in          = (word_in != '0) ? PH_ARGLEN : PH_DRAIN;
                  end
               end
               PH_ARGLEN: begin
                  if (word_done) begin
                     if ({1'b0, byte_count_in} + {2'b0, arg_len} >
                         {1'b0, record_size_ff}) begin
                        phase_in = PH_DRAIN;
                     end else if (arg_len == '0) begin
                        emit_a          = 1'b1;
                        res_a.kind      = KIND_ARG_EMPTY;
                        res_a.arg_index = cur_index_ff;
                        res_a.arg_last  = 1'b1;
                        pad_left_in     = '0;
                        args_left_in    = args_left_ff - 32'd1;
                        cur_index_in    = cur_index_ff + 1'b1;
                        phase_in        = (args_left_in != '0) ? PH_ARGLEN : PH_DRAIN;
                     end else begin
                        bytes_left_in = arg_len;
                        pad_left_in   = 2'd0 - arg_len[1:0];
                        phase_in      = PH_DATA;
                     end
                  end
               end
               PH_DATA: begin
                  bytes_left_in   = bytes_left_ff - 16'd1;
                  emit_a          = 1'b1;
                  res_a.kind      = KIND_ARG_BYTE;
                  res_a.arg_index = cur_index_ff;
                  res_a.arg_byte  = req_data_byte;
                  res_a.arg_last  = bytes_left_in == '0;
                  if (bytes_left_in == '0) begin
                     args_left_in = args_left_ff - 32'd1;
                     cur_index_in = cur_index_ff + 1'b1;
                     if (pad_left_ff != '0) begin
                        phase_in = PH_PAD;
                     end else begin
                        phase_in = (args_left_in != '0) ? PH_ARGLEN : PH_DRAIN;
                     end
                  end
               end
               PH_PAD: begin
                  pad_left_in = pad_left_ff - 2'd1;
                  if (pad_left_in == '0) begin
                     phase_in = (args_left_ff != '0) ? PH_ARGLEN : PH_DRAIN;
                  end
               end
               PH_SIZE, PH_DRAIN: begin
               end
               default: begin
               end
            endcase
            // final byte of the record
            if (byte_count_in >= record_size_ff) begin
               emit_b     = 1'b1;
               res_b.kind = ((phase_in == PH_DRAIN || phase_in == PH_PAD) &&
                             args_left_in == '0) ? KIND_MSG_END : KIND_OVERRUN;
               phase_in      = PH_SIZE;
               byte_count_in = '0;
               word_in       = '0;
            end
         end
      end
   end

   // pack results into queue slots
   always_comb begin
      push0 = res_a;
      push1 = res_b;
      push_cnt = {1'b0, emit_a} + {1'b0, emit_b};
      if (!emit_a) begin
         push0 = res_b;
      end
      if (push_cnt == 2'd2) begin
         push1.last = 1'b1;
      end else begin
         push0.last = 1'b1;
      end
   end

   // state, configuration and queue registers
   always_ff @(posedge clock) begin
      if (reset) begin
         version_first_ff  <= VERSION_FIRST_RESET;
         version_second_ff <= VERSION_SECOND_RESET;
         max_size_ff       <= MAX_SIZE_RESET;
         phase_ff          <= PH_SIZE;
         byte_count_ff     <= '0;
         record_size_ff    <= '0;
         word_ff           <= '0;
         held_vok_ff       <= 1'b0;
         held_status_ff    <= '0;
         args_left_ff      <= '0;
         cur_index_ff      <= '0;
         bytes_left_ff     <= '0;
         pad_left_ff       <= '0;
         wr_ptr_ff         <= '0;
         rd_ptr_ff         <= '0;
         cnt_ff            <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_VERSION_FIRST:  version_first_ff  <= csr_data;
               CSR_VERSION_SECOND: version_second_ff <= csr_data;
               CSR_MAX_SIZE:       max_size_ff       <= csr_data[16:0];
               default: begin
               end
            endcase
         end
         phase_ff       <= phase_in;
         byte_count_ff  <= byte_count_in;
         record_size_ff <= record_size_in;
         word_ff        <= word_in;
         held_vok_ff    <= held_vok_in;
         held_status_ff <= held_status_in;
         args_left_ff   <= args_left_in;
         cur_index_ff   <= cur_index_in;
         bytes_left_ff  <= bytes_left_in;
         pad_left_ff    <= pad_left_in;
         wr_ptr_ff      <= wr_ptr_ff + PTR_BITS'(push_cnt);
         rd_ptr_ff      <= rd_ptr_ff + PTR_BITS'(rsp_take);
         cnt_ff         <= cnt_ff + CNT_BITS'(push_cnt) - CNT_BITS'(rsp_take);
      end
      // queue payload needs no reset
      if (push_cnt != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         fifo_ff[wr_ptr_ff + PTR_BITS'(1)] <= push1;
      end
   end

   // queue head drives the result channel
   assign rsp_kind        = fifo_ff[rd_ptr_ff].kind;
   assign rsp_version_ok  = fifo_ff[rd_ptr_ff].version_ok;
   assign rsp_status_word = fifo_ff[rd_ptr_ff].status_word;
   assign rsp_arg_count   = fifo_ff[rd_ptr_ff].arg_count;
   assign rsp_arg_index   = fifo_ff[rd_ptr_ff].arg_index;
   assign rsp_arg_byte    = fifo_ff[rd_ptr_ff].arg_byte;
   assign rsp_arg_last    = fifo_ff[rd_ptr_ff].arg_last;
   assign rsp_last        = fifo_ff[rd_ptr_ff].last;

   // checks
   `RRD_ASSERT_ALWAYS(a_queue_bound, cnt_ff <= CNT_BITS'(DEPTH), "result queue overflow")
   `RRD_ASSERT_IMPLY(a_room_on_take, req_take, cnt_ff <= CNT_BITS'(DEPTH - 2),
                     "no room for a byte's results")
   `RRD_ASSERT_IMPLY(a_size_range, phase_ff != PH_SIZE,
                     record_size_ff >= 17'd16 && byte_count_ff < record_size_ff,
                     "record size or count out of range")
   `RRD_ASSERT_IMPLY(a_size_count, phase_ff == PH_SIZE, byte_count_ff < 17'd4,
                     "size word count out of range")
   `RRD_ASSERT_IMPLY(a_pair_end, push_cnt == 2'd2,
                     push1.kind == KIND_MSG_END || push1.kind == KIND_OVERRUN,
                     "second result is not a record end")

endmodule
